[sv/fdrle_pkg.sv]
// Shared types and constants for the frame delta run-length decoder.
`timescale 1ns / 1ps
`default_nettype none

package fdrle_pkg;

  // Default frame size in display bytes.
  localparam int DEF_FRAME_BYTES = 1024;

  // Field widths of the result transaction.
  localparam int ADDR_W = 10;
  localparam int DATA_W = 8;
  localparam int RUN_W  = 8;

  // Opcode values and field masks of the compressed stream.
  localparam logic [7:0] OP_BIG_SKIP  = 8'h00;
  localparam logic [7:0] OP_BIG_COPY  = 8'h40;
  localparam logic [7:0] OP_REP_FLAG  = 8'h80;
  localparam logic [7:0] OP_COPY_FLAG = 8'h40;
  localparam logic [7:0] OP_REP_MASK  = 8'h7f;
  localparam logic [7:0] OP_HI_MASK   = 8'h38;

  // What the decoder expects the next byte to be.
  typedef enum logic [2:0] {
    MODE_OPCODE   = 3'd0,
    MODE_SKIPLEN  = 3'd1,
    MODE_COPYLEN  = 3'd2,
    MODE_LITERAL  = 3'd3,
    MODE_REPVALUE = 3'd4
  } mode_t;

  // One result transaction.
  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic [RUN_W-1:0]  run_length;
    logic              frame_end;
  } result_t;

endpackage

`default_nettype wire

[sv/fdrle_decode.sv]
// Decode state registers and the per-byte decode step.
`timescale 1ns / 1ps
`default_nettype none

module fdrle_decode
  import fdrle_pkg::*;
#(
  parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] code_byte,
  output result_t         result,
  output logic            has_result
);

  // Room for a position that runs past the frame by one code's length.
  localparam int POS_W = $clog2(FRAME_BYTES + 520);
  localparam logic [POS_W-1:0] FRAME_POS = POS_W'(FRAME_BYTES);

  mode_t            mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [8:0]       lit_r, lit_nxt;
  logic [2:0]       skip_r, skip_nxt;
  logic [7:0]       rep_r, rep_nxt;

  logic [POS_W-1:0] pos_adv;
  logic [POS_W-1:0] base;
  logic [POS_W-1:0] room;
  logic [8:0]       lit_dec;
  logic [2:0]       copy_cnt;
  logic [2:0]       skip_cnt;
  logic             done;
  logic             we;
  logic [RUN_W-1:0] run;
  logic             fend;
  logic             in_frame;

  assign in_frame = (pos_r < FRAME_POS);
  assign room     = FRAME_POS - pos_r;
  assign lit_dec  = (lit_r == 9'd0) ? 9'd0 : (lit_r - 9'd1);

  // Next state and result for the byte at the input register.
  always_comb begin
    mode_nxt = mode_r;
    lit_nxt  = lit_r;
    skip_nxt = skip_r;
    rep_nxt  = rep_r;
    pos_adv  = pos_r;
    base     = pos_r;
    copy_cnt = 3'd0;
    skip_cnt = 3'd0;
    done     = 1'b0;
    we       = 1'b0;
    run      = '0;
    case (mode_r)
      MODE_SKIPLEN: begin
        pos_adv = pos_r + POS_W'(code_byte) + POS_W'(1);
        done    = 1'b1;
      end
      MODE_COPYLEN: begin
        lit_nxt  = {1'b0, code_byte} + 9'd1;
        skip_nxt = 3'd0;
        mode_nxt = MODE_LITERAL;
      end
      MODE_LITERAL: begin
        we      = in_frame;
        run     = RUN_W'(1);
        lit_nxt = lit_dec;
        if (lit_dec == 9'd0) begin
          pos_adv  = pos_r + POS_W'(1) + POS_W'(skip_r);
          skip_nxt = 3'd0;
          done     = 1'b1;
        end else begin
          pos_adv = pos_r + POS_W'(1);
        end
      end
      MODE_REPVALUE: begin
        if (in_frame) begin
          we  = 1'b1;
          run = (POS_W'(rep_r) > room) ? room[RUN_W-1:0] : rep_r;
        end
        pos_adv = pos_r + POS_W'(rep_r);
        done    = 1'b1;
      end
      default: begin
        if (code_byte == OP_BIG_SKIP) begin
          mode_nxt = MODE_SKIPLEN;
        end else if (code_byte == OP_BIG_COPY) begin
          mode_nxt = MODE_COPYLEN;
        end else if ((code_byte & OP_REP_FLAG) != 8'h00) begin
          rep_nxt  = (code_byte & OP_REP_MASK) + 8'd1;
          mode_nxt = MODE_REPVALUE;
        end else begin
          // Short codes: skip then copy, or copy then skip.
          if ((code_byte & OP_COPY_FLAG) == 8'h00) begin
            base     = pos_r + POS_W'(code_byte[5:3]);
            copy_cnt = code_byte[2:0];
            skip_cnt = 3'd0;
          end else begin
            base     = pos_r;
            copy_cnt = 3'(((code_byte & OP_HI_MASK) >> 3));
            skip_cnt = code_byte[2:0];
          end
          if (copy_cnt == 3'd0) begin
            pos_adv = base + POS_W'(skip_cnt);
            done    = 1'b1;
          end else begin
            pos_adv  = base;
            lit_nxt  = {6'd0, copy_cnt};
            skip_nxt = skip_cnt;
            mode_nxt = MODE_LITERAL;
          end
        end
      end
    endcase

    // A finished code returns to opcode mode and may close the frame.
    fend    = done && (pos_adv >= FRAME_POS);
    pos_nxt = fend ? '0 : pos_adv;
    if (done) begin
      mode_nxt = MODE_OPCODE;
    end
  end

  // Address, data and run length are zero unless a write is performed.
  always_comb begin
    result.write_enable = we;
    result.address      = we ? pos_r[ADDR_W-1:0] : '0;
    result.data         = we ? code_byte : '0;
    result.run_length   = we ? run : '0;
    result.frame_end    = fend;
    has_result          = we || fend;
  end

  // Decode state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OPCODE;
      pos_r  <= '0;
      lit_r  <= '0;
      skip_r <= '0;
      rep_r  <= '0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      lit_r  <= lit_nxt;
      skip_r <= skip_nxt;
      rep_r  <= rep_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/fdrle_out_buf.sv]
// One-entry output register for result transactions.
`timescale 1ns / 1ps
`default_nettype none

module fdrle_out_buf
  import fdrle_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t load_data,
  input  wire logic    out_stall,
  output logic         ready,
  output logic         out_valid,
  output result_t      out_data
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  // The entry can take a new result when empty or being taken this cycle.
  assign ready     = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

[sv/frame_delta_rle_decoder_core.sv]
// Top level of the frame delta run-length decoder.
//
//  Channel | Direction | Ports                                   | Handshake
//  in_     | input     | in_code_byte                            | in_valid / in_stall
//  out_    | output    | out_write_enable, out_address, out_data | out_valid / out_stall
//          |           | out_run_length, out_frame_end           |
//
// One byte per cycle is sustained while a stalled result does not hold the input register;
// a result is presented once the input register has taken its byte and the decode step
// has loaded it into the output register, and it stays there until it is taken.
// Bytes that only move the decoder state produce no result transaction.
// Reset is synchronous and clears the decoder state and both valid flags.
// A stalled result holds the output register; the input register keeps taking bytes
// while the byte it holds produces no result or the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module frame_delta_rle_decoder_core
  import fdrle_pkg::*;
#(
  parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_code_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_write_enable,
  output logic [ADDR_W-1:0]      out_address,
  output logic [DATA_W-1:0]      out_data,
  output logic [RUN_W-1:0]       out_run_length,
  output logic                   out_frame_end
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       advance;
  logic       accept;
  logic       has_result;
  logic       ob_ready;
  result_t    step_res;
  result_t    ob_data;

  // The held byte moves on when its result, if any, has a place to go.
  assign advance      = in_valid_r && (!has_result || ob_ready);
  assign in_stall     = in_valid_r && !advance;
  assign accept       = in_valid && !in_stall;
  assign in_valid_nxt = accept || (in_valid_r && !advance);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_code_byte;
    end
  end

  // Decode step.
  fdrle_decode #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .code_byte (in_byte_r),
    .result    (step_res),
    .has_result(has_result)
  );

  // Result register.
  fdrle_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance && has_result),
    .load_data(step_res),
    .out_stall(out_stall),
    .ready    (ob_ready),
    .out_valid(out_valid),
    .out_data (ob_data)
  );

  assign out_write_enable = ob_data.write_enable;
  assign out_address      = ob_data.address;
  assign out_data         = ob_data.data;
  assign out_run_length   = ob_data.run_length;
  assign out_frame_end    = ob_data.frame_end;

endmodule

`default_nettype wire

[sv/fdrle_checker.sv]
// Port-level checks for the frame delta run-length decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fdrle_checker
  import fdrle_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_write_enable,
  input wire logic [ADDR_W-1:0] out_address,
  input wire logic [DATA_W-1:0] out_data,
  input wire logic [RUN_W-1:0]  out_run_length,
  input wire logic              out_frame_end
);

  // A stalled result transaction stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_address) && $stable(out_data)
      && $stable(out_run_length) && $stable(out_write_enable) && $stable(out_frame_end))
    else $error("stalled result transaction changed");

  // Every transaction carries a write or a frame end.
  a_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_write_enable || out_frame_end)
    else $error("result transaction with neither write nor frame end");

  // A write fills between one and 128 bytes.
  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |-> out_run_length != 0 && out_run_length <= 8'd128)
    else $error("write run length out of range");

  // A frame end without a write has zero payload fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |->
      out_address == 0 && out_data == 0 && out_run_length == 0)
    else $error("non-write transaction has nonzero fields");

  // No result is presented right after a reset edge.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind frame_delta_rle_decoder_core fdrle_checker u_fdrle_checker (.*);

`default_nettype wire

[tb/frame_delta_rle_decoder_core_tb.sv]
// Self-checking testbench for the frame delta run-length decoder core.
`timescale 1ns / 1ps

module frame_delta_rle_decoder_core_tb;
  import fdrle_pkg::*;

  localparam int FRAME_BYTES = DEF_FRAME_BYTES;
  localparam int MAX_WAIT = 6;
  localparam int ITEM_TARGET = 900;
  localparam int QUIET_LIMIT = 200;
  localparam int SETTLE_CYCLES = 10;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_code_byte;
  logic out_valid;
  logic out_stall;
  logic out_write_enable;
  logic [ADDR_W-1:0] out_address;
  logic [DATA_W-1:0] out_data;
  logic [RUN_W-1:0] out_run_length;
  logic out_frame_end;

  // Write and frame-end commands predicted for bytes already accepted.
  result_t display_cmds[$];
  int mismatches;
  int items_sent;
  bit idle_on;

  // Decoder state as the stream has driven it so far.
  mode_t dec_mode;
  int frame_pos;
  int lits_left;
  int skip_tail;
  int rep_count;

  frame_delta_rle_decoder_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_code_byte(in_code_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_write_enable(out_write_enable),
    .out_address(out_address),
    .out_data(out_data),
    .out_run_length(out_run_length),
    .out_frame_end(out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Ends a code: back to opcode mode, and wraps the position at the frame end.
  function automatic logic close_code();
    dec_mode = MODE_OPCODE;
    if (frame_pos >= FRAME_BYTES) begin
      frame_pos = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the decoder state by one stream byte and queues the command it gives.
  function automatic void decode_stream_byte(input logic [7:0] b);
    int start_pos;
    int run;
    int hi;
    int lo;
    int copy_n;
    int skip_n;
    logic we;
    logic fend;
    result_t cmd;
    start_pos = frame_pos;
    run = 0;
    we = 1'b0;
    fend = 1'b0;
    case (dec_mode)
      MODE_SKIPLEN: begin
        frame_pos += int'(b) + 1;
        fend = close_code();
      end
      MODE_COPYLEN: begin
        lits_left = int'(b) + 1;
        skip_tail = 0;
        dec_mode = MODE_LITERAL;
      end
      MODE_LITERAL: begin
        // A literal at or past the frame size is dropped.
        we = (start_pos < FRAME_BYTES);
        run = 1;
        frame_pos += 1;
        if (lits_left > 0) lits_left -= 1;
        if (lits_left == 0) begin
          frame_pos += skip_tail;
          skip_tail = 0;
          fend = close_code();
        end
      end
      MODE_REPVALUE: begin
        // A run crossing the frame end is clipped, but the position moves by the full count.
        run = rep_count;
        if (start_pos < FRAME_BYTES) begin
          we = 1'b1;
          if (run > FRAME_BYTES - start_pos) run = FRAME_BYTES - start_pos;
        end
        frame_pos += rep_count;
        fend = close_code();
      end
      default: begin
        if (b == OP_BIG_SKIP) begin
          dec_mode = MODE_SKIPLEN;
        end else if (b == OP_BIG_COPY) begin
          dec_mode = MODE_COPYLEN;
        end else if ((b & OP_REP_FLAG) != 0) begin
          rep_count = int'(b & OP_REP_MASK) + 1;
          dec_mode = MODE_REPVALUE;
        end else begin
          hi = int'((b & OP_HI_MASK) >> 3);
          lo = int'(b[2:0]);
          if ((b & OP_COPY_FLAG) == 0) begin
            frame_pos += hi;
            copy_n = lo;
            skip_n = 0;
          end else begin
            copy_n = hi;
            skip_n = lo;
          end
          // With nothing to copy the short code is a pure skip.
          if (copy_n == 0) begin
            frame_pos += skip_n;
            fend = close_code();
          end else begin
            lits_left = copy_n;
            skip_tail = skip_n;
            dec_mode = MODE_LITERAL;
          end
        end
      end
    endcase
    if (we || fend) begin
      cmd.write_enable = we;
      cmd.address = we ? start_pos[ADDR_W-1:0] : '0;
      cmd.data = we ? b : '0;
      cmd.run_length = we ? run[RUN_W-1:0] : '0;
      cmd.frame_end = fend;
      display_cmds.push_back(cmd);
    end
  endfunction

  // Sends one stream byte, after a random gap while idle_on is set, and waits until it is accepted.
  task automatic send_byte(input logic [7:0] code);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_code_byte <= code;
    do @(posedge clk); while (in_stall !== 1'b0);
    decode_stream_byte(code);
    items_sent++;
  endtask

  task automatic send_literals(input int count);
    repeat (count) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Holds the input off until every predicted command has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (display_cmds.size() != 0);
  endtask

  // One code of every kind, with the smallest long-code lengths and the smallest and largest literal values.
  task automatic test_each_opcode();
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h4f);
    send_byte(8'hff);
    send_byte(8'h38);
    send_byte(8'h47);
    send_byte(OP_BIG_COPY);
    send_byte(8'h00);
    send_byte(8'h5a);
    send_byte(OP_REP_FLAG);
    send_byte(8'h3c);
    send_byte(OP_BIG_SKIP);
    send_byte(8'h00);
  endtask

  // A clipped repeat at the end of one frame, then literals past the end of the next.
  task automatic test_frame_boundary();
    repeat (3) begin
      send_byte(OP_BIG_SKIP);
      send_byte(8'hff);
    end
    send_byte(OP_BIG_SKIP);
    send_byte(8'hd5);
    send_byte(8'hff);
    send_byte(8'ha5);
    repeat (3) begin
      send_byte(OP_BIG_SKIP);
      send_byte(8'hff);
    end
    send_byte(OP_BIG_SKIP);
    send_byte(8'hfe);
    send_byte(8'h0a);
    send_byte(8'h11);
    send_byte(8'h22);
  endtask

  // Mostly well-formed codes with random content, plus stray and cut-short codes.
  task automatic send_random_code();
    int kind;
    int len;
    logic [7:0] op;
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      send_byte(OP_BIG_SKIP);
      send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 7) begin
      op = 8'($urandom_range(1, int'(OP_COPY_FLAG) - 1));
      send_byte(op);
      send_literals(int'(op[2:0]));
    end else if (kind < 10) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
      send_byte(OP_BIG_COPY);
      send_byte(8'(len));
      send_literals(len + 1);
    end else if (kind < 14) begin
      op = 8'($urandom_range(int'(OP_COPY_FLAG) + 1, int'(OP_REP_MASK)));
      send_byte(op);
      send_literals(int'(op[5:3]));
    end else if (kind < 18) begin
      send_byte(8'($urandom_range(int'(OP_REP_FLAG), 255)));
      send_byte(8'($urandom_range(0, 255)));
    end else if (kind == 18) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      // A copy cut short, so the codes that follow are taken as literals.
      len = $urandom_range(1, 7);
      send_byte(OP_BIG_COPY);
      send_byte(8'(len));
      send_literals($urandom_range(0, len - 1));
    end
  endtask

  // Random stream in stretches of about 100 bytes with changing idle behavior.
  task automatic test_random_stream();
    int stretch;
    stretch = items_sent / 100;
    while (items_sent < ITEM_TARGET) begin
      send_random_code();
      if (items_sent / 100 != stretch) begin
        stretch = items_sent / 100;
        idle_on = (stretch % 4 != 2);
        if (stretch % 3 == 0) drain_results();
      end
    end
  endtask

  function automatic void compare_field(input string label, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
    end
  endfunction

  // Takes result transactions with random stalls and checks them in order.
  initial begin : result_checker
    result_t got;
    result_t want;
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.write_enable = out_write_enable;
      got.address = out_address;
      got.data = out_data;
      got.run_length = out_run_length;
      got.frame_end = out_frame_end;
      if (display_cmds.size() == 0) begin
        mismatches++;
        $display({"%0t: unexpected result, expected none, ",
                  "actual we=%0b addr=%0d data=0x%0h run=%0d fend=%0b"},
                 $time, got.write_enable, got.address, got.data, got.run_length,
                 got.frame_end);
      end else begin
        want = display_cmds.pop_front();
        compare_field("write_enable", 16'(want.write_enable), 16'(got.write_enable));
        compare_field("address", 16'(want.address), 16'(got.address));
        compare_field("data", 16'(want.data), 16'(got.data));
        compare_field("run_length", 16'(want.run_length), 16'(got.run_length));
        compare_field("frame_end", 16'(want.frame_end), 16'(got.frame_end));
      end
    end
  end

  // Ends the run when neither channel has moved a transaction for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Reset, then the tests in turn, then the final verdict.
  initial begin
    mismatches = 0;
    items_sent = 0;
    idle_on = 1'b1;
    dec_mode = MODE_OPCODE;
    frame_pos = 0;
    lits_left = 0;
    skip_tail = 0;
    rep_count = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_code_byte <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_each_opcode();
    test_frame_boundary();
    test_random_stream();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
sv/fdrle_pkg.sv
sv/fdrle_decode.sv
sv/fdrle_out_buf.sv
sv/frame_delta_rle_decoder_core.sv
sv/fdrle_checker.sv
tb/frame_delta_rle_decoder_core_tb.sv
